/* src/multilevel_feedback_dispatcher_defines.svh */
// ----------------------------------------------------------------------------
// Multilevel feedback dispatcher assertion macros
// Concurrent assertion wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_DISPATCHER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_DISPATCHER_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define MFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MFD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mfd_pkg.sv */
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared constants, codes and control types of the feedback dispatcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfd_pkg;

  localparam int MFD_MAX_PROCS = 64;
  localparam int LEVELS        = 4;
  localparam int ID_W          = 6;
  localparam int PRIO_W        = 2;
  localparam int CPU_W         = 10;
  localparam int STAT_W        = 3;
  localparam int TICK_W        = 20;
  localparam int PEND_W        = 7;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 40;

  localparam logic ACT_ARRIVE = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [PRIO_W-1:0] LVL_RT   = 2'd0;
  localparam logic [PRIO_W-1:0] LVL_HIGH = 2'd1;
  localparam logic [PRIO_W-1:0] LVL_MED  = 2'd2;
  localparam logic [PRIO_W-1:0] LVL_LOW  = 2'd3;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPT = 3'd0,
    ST_REJECT = 3'd1,
    ST_RUN    = 3'd2,
    ST_FIN    = 3'd3,
    ST_IDLE   = 3'd4
  } status_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } mfd_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic empty;
  } mfd_stat_t;

endpackage

/* src/mfd_ctrl.sv */
// ----------------------------------------------------------------------------
// mfd_ctrl
// Sequencer: capture a beat, wait for the queue read (and on a busy tick the time read), commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfd_ctrl
  import mfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  mfd_stat_t stat,
  output mfd_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK,
    S_RDREM,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  always_comb begin
    out_free    = !out_valid_r || out_tready;
    in_tready   = (state_r == S_IDLE);
    cmd.capture = in_tvalid && (state_r == S_IDLE);
    cmd.commit  = (state_r == S_EXEC) && out_free;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.capture) state_r <= S_CHK;
        end
        S_CHK: begin
          if (!stat.is_tick || stat.empty) state_r <= S_EXEC;
          else state_r <= S_RDREM;
        end
        S_RDREM: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.commit) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

endmodule

/* src/mfd_datapath.sv */
// ----------------------------------------------------------------------------
// mfd_datapath
// Level queues, remaining-time store, pending flags, counters, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfd_datapath
  import mfd_pkg::*;
#(
  parameter int MAX_PROCS = MFD_MAX_PROCS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mfd_cmd_t               cmd,
  output mfd_stat_t              stat,
  input  logic                   in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic [STAT_W-1:0]      out_tuser,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int NUM_IDS = (MAX_PROCS < (1 << ID_W)) ? MAX_PROCS : (1 << ID_W);
  localparam int IDX_W   = $clog2(NUM_IDS);
  localparam int PTR_W   = $clog2(MAX_PROCS);
  localparam int CNT_W   = $clog2(MAX_PROCS + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int FADDR_W = PRIO_W + PTR_W;
  localparam int FDEPTH  = LEVELS << PTR_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_PROCS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCS);
  localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(MAX_PROCS);
  localparam logic [ID_W:0]    ID_LIMIT = (ID_W + 1)'(NUM_IDS);

  logic              act_r;
  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;
  logic [CPU_W-1:0]  need_r;

  logic [PTR_W-1:0]  head_r   [LEVELS];
  logic [CNT_W-1:0]  cnt_r    [LEVELS];
  logic [PTR_W-1:0]  head_nxt [LEVELS];
  logic [CNT_W-1:0]  cnt_nxt  [LEVELS];
  logic [NUM_IDS-1:0] pend_r, pend_nxt;
  logic [PEND_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;

  logic [ID_W-1:0]   fifo_mem [FDEPTH];
  logic [ID_W-1:0]   fifo_q;
  logic [CPU_W-1:0]  rem_mem  [NUM_IDS];
  logic [CPU_W-1:0]  rem_q;

  logic [PRIO_W-1:0] sel_lvl;
  logic              empty;
  logic [FADDR_W-1:0] rd_addr;
  logic [IDX_W-1:0]  pidx;

  logic              push_req, push_en;
  logic [PRIO_W-1:0] push_lvl;
  logic [ID_W-1:0]   push_id;
  logic [FADDR_W-1:0] push_addr;
  logic              rem_req, rem_we;
  logic [IDX_W-1:0]  rem_wa;
  logic [CPU_W-1:0]  rem_wd;

  status_t           res_status;
  logic [ID_W-1:0]   res_id;
  logic [PRIO_W-1:0] res_lvl;
  logic [TICK_W-1:0] res_fin;
  logic [CPU_W-1:0]  res_left;

  status_t           out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [PRIO_W-1:0] out_lvl_r;
  logic [TICK_W-1:0] out_fin_r;
  logic [CPU_W-1:0]  out_left_r;
  logic              out_done_r;

  always_comb begin
    empty   = 1'b1;
    sel_lvl = LVL_LOW;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        sel_lvl = PRIO_W'(l);
        empty   = 1'b0;
      end
    end
  end

  assign rd_addr      = {sel_lvl, head_r[sel_lvl]};
  assign pidx         = fifo_q[IDX_W-1:0];
  assign stat.is_tick = (act_r == ACT_TICK);
  assign stat.empty   = empty;

  always_comb begin
    logic [IDX_W-1:0] aidx;
    logic             id_ok;
    logic [CPU_W-1:0] rem_eff;
    logic [CPU_W-1:0] left;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] tail;

    aidx    = id_r[IDX_W-1:0];
    id_ok   = ({1'b0, id_r} < ID_LIMIT);
    rem_eff = '0;
    left    = '0;
    tail_sum = '0;
    tail     = '0;

    for (int l = 0; l < LEVELS; l++) begin
      head_nxt[l] = head_r[l];
      cnt_nxt[l]  = cnt_r[l];
    end
    pend_nxt     = pend_r;
    pend_cnt_nxt = pend_cnt_r;
    tick_nxt     = tick_r;
    push_req     = 1'b0;
    push_lvl     = prio_r;
    push_id      = id_r;
    push_addr    = '0;
    rem_req      = 1'b0;
    rem_wa       = aidx;
    rem_wd       = need_r;
    res_status   = ST_IDLE;
    res_id       = '0;
    res_lvl      = '0;
    res_fin      = '0;
    res_left     = '0;

    if (act_r == ACT_ARRIVE) begin
      res_id  = id_r;
      res_lvl = prio_r;
      if ((need_r != '0) && id_ok && !pend_r[aidx]) begin
        res_status     = ST_ACCEPT;
        res_left       = need_r;
        pend_nxt[aidx] = 1'b1;
        pend_cnt_nxt   = pend_cnt_r + 1'b1;
        rem_req        = 1'b1;
        push_req       = 1'b1;
      end else begin
        res_status = ST_REJECT;
      end
    end else begin
      tick_nxt = tick_r + 1'b1;
      if (!empty) begin
        rem_eff  = pend_r[pidx] ? rem_q : '0;
        left     = (rem_eff != '0) ? rem_eff - 1'b1 : '0;
        res_id   = fifo_q;
        res_lvl  = sel_lvl;
        res_left = left;
        if (left == '0) begin
          res_status         = ST_FIN;
          res_fin            = tick_r + 1'b1;
          head_nxt[sel_lvl]  = (head_r[sel_lvl] == PTR_LAST) ? '0 : head_r[sel_lvl] + 1'b1;
          cnt_nxt[sel_lvl]   = cnt_r[sel_lvl] - 1'b1;
          pend_nxt[pidx]     = 1'b0;
          if (pend_cnt_r != '0) pend_cnt_nxt = pend_cnt_r - 1'b1;
        end else begin
          res_status = ST_RUN;
          rem_req    = 1'b1;
          rem_wa     = pidx;
          rem_wd     = left;
          if (sel_lvl != LVL_RT) begin
            head_nxt[sel_lvl] = (head_r[sel_lvl] == PTR_LAST) ? '0 : head_r[sel_lvl] + 1'b1;
            cnt_nxt[sel_lvl]  = cnt_r[sel_lvl] - 1'b1;
            push_req = 1'b1;
            push_id  = fifo_q;
            push_lvl = (sel_lvl == LVL_LOW) ? LVL_LOW : sel_lvl + 1'b1;
          end
        end
      end
    end

    if (push_req && (cnt_nxt[push_lvl] != CNT_FULL)) begin
      tail_sum  = SUM_W'(head_nxt[push_lvl]) + SUM_W'(cnt_nxt[push_lvl]);
      tail      = (tail_sum >= SUM_WRAP) ? tail_sum - SUM_WRAP : tail_sum;
      push_addr = {push_lvl, tail[PTR_W-1:0]};
      cnt_nxt[push_lvl] = cnt_nxt[push_lvl] + 1'b1;
    end else begin
      push_req = 1'b0;
    end
  end

  assign push_en = cmd.commit && push_req;
  assign rem_we  = cmd.commit && rem_req;

  always_ff @(posedge clk) begin
    if (push_en) fifo_mem[push_addr] <= push_id;
    fifo_q <= fifo_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    rem_q <= rem_mem[pidx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_tuser;
      id_r   <= in_tdata[ID_W-1:0];
      prio_r <= in_tdata[ID_W +: PRIO_W];
      need_r <= in_tdata[ID_W + PRIO_W +: CPU_W];
    end
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_lvl_r    <= res_lvl;
      out_fin_r    <= res_fin;
      out_left_r   <= res_left;
      out_done_r   <= (pend_cnt_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
      pend_r     <= '0;
      pend_cnt_r <= '0;
      tick_r     <= '0;
    end else if (cmd.commit) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= head_nxt[l];
        cnt_r[l]  <= cnt_nxt[l];
      end
      pend_r     <= pend_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      tick_r     <= tick_nxt;
    end
  end

  assign out_tuser = out_status_r;
  assign out_tdata = {1'b0, out_done_r, out_left_r, out_fin_r, out_lvl_r, out_id_r};

endmodule

/* src/multilevel_feedback_dispatcher.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_dispatcher
// Four-level feedback scheduler: real-time, high, medium and low queues.
// ----------------------------------------------------------------------------
// Input channel in_*: one beat per arrive or tick. in_tuser is the action
// (0 arrive, 1 tick); in_tdata carries id, requested level and CPU need.
// Result channel out_*: one beat per input beat, in order. out_tuser is the
// status code; out_tdata carries served id, level, finish time, time left
// and the all-done flag.
// Result path: capture, a check state, and for a tick with a non-empty queue a
// remaining-time read state, then the commit into the output register, which
// raises out_tvalid. in_tready rises with out_tvalid and the next beat can be
// taken in that same cycle; only one beat is worked on at a time. A busy tick
// waits for the queue-head read and then the remaining-time read, each through a registered memory port.
// A finished result waits in the output register while the next beat is
// accepted and worked on; a second result waits in the sequencer until the
// receiver takes the first one.
// Reset (synchronous, active low) empties all queues, clears every pending
// flag, the tick counter and the pending count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multilevel_feedback_dispatcher
  import mfd_pkg::*;
#(
  parameter int MAX_PROCS = MFD_MAX_PROCS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // process_id, priority_req, cpu_time
  input  logic                   in_tuser,   // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // ran_id, ran_level, finish_time,
                                             // time_left, all_done
  output logic [STAT_W-1:0]      out_tuser   // status
);

  mfd_cmd_t  cmd;
  mfd_stat_t stat;

  mfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mfd_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

endmodule

/* src/mfd_checker.sv */
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks of the feedback dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multilevel_feedback_dispatcher_defines.svh"

module mfd_checker
  import mfd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]      out_tuser
);

  `MFD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result beat changed")
  `MFD_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid, "result beat right after reset")
  `MFD_ASSERT(a_one_in_flight, in_tvalid && in_tready |=> !in_tready, "second beat taken while busy")
  `MFD_ASSERT(a_idle_zero, out_tvalid && (out_tuser == ST_IDLE) |-> (out_tdata[37:0] == '0), "idle tick with nonzero fields")

endmodule

bind multilevel_feedback_dispatcher mfd_checker u_mfd_checker (.*);

/* bench/multilevel_feedback_dispatcher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_dispatcher_tb
// Self-checking bench for the four-level feedback dispatcher. A directed table
// covers idle and rejected beats, field extremes and every queue level. A long
// random run of arrivals and ticks follows. A scoreboard model of the queues
// predicts each result beat. Both stream sides idle in random bursts during
// the random run, except near its end.
// ----------------------------------------------------------------------------

module multilevel_feedback_dispatcher_tb;
  import mfd_pkg::*;

  localparam int RANDOM_BEATS = 830;
  localparam int QUIET_BEATS  = 150;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    status_t             status;
    logic [ID_W-1:0]     id;
    logic [PRIO_W-1:0]   lvl;
    logic [TICK_W-1:0]   fin;
    logic [CPU_W-1:0]    left;
    logic                done;
  } sched_result_t;

  typedef struct {
    logic                act;
    logic [ID_W-1:0]     pid;
    logic [PRIO_W-1:0]   prio;
    logic [CPU_W-1:0]    need;
    bit                  typed;
    sched_result_t       want;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  // scheduler image: per-level rings, remaining quanta, tick clock
  logic [ID_W-1:0]  ring      [LEVELS][MFD_MAX_PROCS];
  int               ring_head [LEVELS] = '{default: 0};
  int               ring_cnt  [LEVELS] = '{default: 0};
  logic [CPU_W-1:0] need_left [MFD_MAX_PROCS] = '{default: '0};
  logic [TICK_W-1:0] tick_now = '0;
  int               pending_n = 0;
  int               pending_peak = 0;

  sched_result_t due_results[$];
  int  errors = 0;
  int  beats_seen = 0;
  int  status_hits [5] = '{default: 0};
  int  gap_pct = 0;
  int  stall_pct = 0;
  int  stall_left = 0;
  int  cycle_n;

  multilevel_feedback_dispatcher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void ring_push(int lv, logic [ID_W-1:0] pid);
    if (ring_cnt[lv] < MFD_MAX_PROCS) begin
      ring[lv][(ring_head[lv] + ring_cnt[lv]) % MFD_MAX_PROCS] = pid;
      ring_cnt[lv]++;
    end
  endfunction

  function automatic void ring_pop(int lv);
    if (ring_cnt[lv] > 0) begin
      ring_head[lv] = (ring_head[lv] + 1) % MFD_MAX_PROCS;
      ring_cnt[lv]--;
    end
  endfunction

  function automatic sched_result_t schedule_step(logic act, logic [ID_W-1:0] pid,
                                                  logic [PRIO_W-1:0] prio,
                                                  logic [CPU_W-1:0] need);
    sched_result_t r;
    int lv;
    logic [ID_W-1:0] sid;
    r.status = ST_IDLE;
    r.id     = '0;
    r.lvl    = LVL_RT;
    r.fin    = '0;
    r.left   = '0;
    if (act == ACT_ARRIVE) begin
      r.id  = pid;
      r.lvl = prio;
      if (need == '0 || need_left[pid] != '0) begin
        r.status = ST_REJECT;
      end else begin
        need_left[pid] = need;
        pending_n++;
        ring_push(int'(prio), pid);
        r.status = ST_ACCEPT;
        r.left   = need;
      end
    end else begin
      lv = 0;
      while (lv < LEVELS && ring_cnt[lv] == 0) lv++;
      if (lv < LEVELS) begin
        sid = ring[lv][ring_head[lv]];
        if (need_left[sid] != '0) need_left[sid] = need_left[sid] - 1'b1;
        r.id   = sid;
        r.lvl  = lv[PRIO_W-1:0];
        r.left = need_left[sid];
        if (r.left == '0) begin
          r.fin = tick_now + 1'b1;
          ring_pop(lv);
          if (pending_n > 0) pending_n--;
          r.status = ST_FIN;
        end else begin
          r.status = ST_RUN;
          if (lv != int'(LVL_RT)) begin
            ring_pop(lv);
            ring_push((lv == int'(LVL_LOW)) ? lv : lv + 1, sid);
          end
        end
      end
      tick_now = tick_now + 1'b1;
    end
    r.done = (pending_n == 0);
    if (pending_n > pending_peak) pending_peak = pending_n;
    return r;
  endfunction

  task automatic flag_mismatch(string field, int unsigned got, int unsigned want);
    $display("[%0t] beat %0d: %s got %0d, want %0d", $time, beats_seen, field, got, want);
    errors++;
  endtask

  // hold each beat until the handshake, then record its expected result
  task automatic send_beat(logic act, logic [ID_W-1:0] pid, logic [PRIO_W-1:0] prio,
                           logic [CPU_W-1:0] need, bit typed, sched_result_t want);
    sched_result_t predicted;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W - ID_W - PRIO_W - CPU_W){1'b0}}, need, prio, pid};
    do @(posedge clk); while (!in_tready);
    predicted = schedule_step(act, pid, prio, need);
    due_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $display("[%0t] result beat with nothing outstanding", $time);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_tuser !== want.status)
          flag_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[5:0] !== want.id)
          flag_mismatch("ran_id", 32'(out_tdata[5:0]), 32'(want.id));
        if (out_tdata[7:6] !== want.lvl)
          flag_mismatch("ran_level", 32'(out_tdata[7:6]), 32'(want.lvl));
        if (out_tdata[27:8] !== want.fin)
          flag_mismatch("finish_time", 32'(out_tdata[27:8]), 32'(want.fin));
        if (out_tdata[37:28] !== want.left)
          flag_mismatch("time_left", 32'(out_tdata[37:28]), 32'(want.left));
        if (out_tdata[38] !== want.done)
          flag_mismatch("all_done", 32'(out_tdata[38]), 32'(want.done));
        if (int'(want.status) < 5) status_hits[int'(want.status)]++;
      end
      beats_seen++;
    end
  end

  initial begin : watchdog
    cycle_n = 0;
    while (cycle_n < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_n++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_n,
             due_results.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan[$];
    sched_result_t none;
    plan_row_t row;
    logic act;
    logic [ID_W-1:0] pid;
    logic [PRIO_W-1:0] prio;
    logic [CPU_W-1:0] need;
    int tick_pct;
    int pick;
    int start;

    none = '{ST_ACCEPT, 6'd0, LVL_RT, 20'd0, 10'd0, 1'b0};
    plan.push_back('{ACT_TICK,   6'd63, LVL_LOW,  10'd1023, 1'b1,
                     '{ST_IDLE,   6'd0,  LVL_RT,   20'd0, 10'd0,    1'b1}});
    plan.push_back('{ACT_ARRIVE, 6'd0,  LVL_RT,   10'd0,    1'b1,
                     '{ST_REJECT, 6'd0,  LVL_RT,   20'd0, 10'd0,    1'b1}});
    plan.push_back('{ACT_ARRIVE, 6'd63, LVL_LOW,  10'd1023, 1'b1,
                     '{ST_ACCEPT, 6'd63, LVL_LOW,  20'd0, 10'd1023, 1'b0}});
    plan.push_back('{ACT_ARRIVE, 6'd63, LVL_HIGH, 10'd5,    1'b1,
                     '{ST_REJECT, 6'd63, LVL_HIGH, 20'd0, 10'd0,    1'b0}});
    plan.push_back('{ACT_ARRIVE, 6'd1,  LVL_RT,   10'd2,    1'b0, none});
    plan.push_back('{ACT_ARRIVE, 6'd2,  LVL_HIGH, 10'd3,    1'b0, none});
    plan.push_back('{ACT_ARRIVE, 6'd3,  LVL_MED,  10'd2,    1'b0, none});
    repeat (7) plan.push_back('{ACT_TICK, 6'd0, LVL_RT, 10'd0, 1'b0, none});
    plan.push_back('{ACT_ARRIVE, 6'd1,  LVL_RT,   10'd1,    1'b0, none});
    plan.push_back('{ACT_TICK,   6'd42, LVL_MED,  10'd682,  1'b0, none});
    plan.push_back('{ACT_TICK,   6'd21, LVL_HIGH, 10'd341,  1'b0, none});
    plan.push_back('{ACT_ARRIVE, 6'd2,  LVL_HIGH, 10'd1,    1'b0, none});
    plan.push_back('{ACT_TICK,   6'd0,  LVL_RT,   10'd0,    1'b0, none});
    plan.push_back('{ACT_TICK,   6'd0,  LVL_RT,   10'd0,    1'b0, none});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      send_beat(row.act, row.pid, row.prio, row.need, row.typed, row.want);
    end

    tick_pct = 50;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n >= RANDOM_BEATS - QUIET_BEATS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (n % 100 == 0) begin
        tick_pct  = ($urandom_range(0, 3) == 0) ? 35 : $urandom_range(45, 70);
        gap_pct   = $urandom_range(0, 1) ? 20 : 0;
        stall_pct = $urandom_range(0, 1) ? 20 : 0;
      end
      pid  = ID_W'($urandom_range(0, MFD_MAX_PROCS - 1));
      prio = PRIO_W'($urandom_range(0, LEVELS - 1));
      need = CPU_W'($urandom_range(1, 12));
      if ($urandom_range(0, 99) < tick_pct) begin
        act  = ACT_TICK;
        need = CPU_W'($urandom_range(0, 1023));
      end else begin
        act  = ACT_ARRIVE;
        pick = $urandom_range(0, 99);
        start = $urandom_range(0, MFD_MAX_PROCS - 1);
        if (pick < 6) begin
          need = '0;
        end else if (pick < 14) begin
          for (int k = 0; k < MFD_MAX_PROCS; k++)
            if (need_left[(start + k) % MFD_MAX_PROCS] != '0)
              pid = ID_W'((start + k) % MFD_MAX_PROCS);
        end else begin
          for (int k = 0; k < MFD_MAX_PROCS; k++)
            if (need_left[(start + k) % MFD_MAX_PROCS] == '0)
              pid = ID_W'((start + k) % MFD_MAX_PROCS);
          if (pick >= 94) begin
            need = CPU_W'($urandom_range(1, 1023));
            prio = PRIO_W'($urandom_range(1, LEVELS - 1));
          end
        end
      end
      send_beat(act, pid, prio, need, 1'b0, none);
    end
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("checked %0d result beats: %0d admitted, %0d refused, %0d partial runs,",
             beats_seen, status_hits[ST_ACCEPT], status_hits[ST_REJECT],
             status_hits[ST_RUN]);
    $display("  %0d completions, %0d idle ticks, peak backlog %0d processes",
             status_hits[ST_FIN], status_hits[ST_IDLE], pending_peak);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/mfd_pkg.sv
src/mfd_ctrl.sv
src/mfd_datapath.sv
src/multilevel_feedback_dispatcher.sv
src/mfd_checker.sv
bench/multilevel_feedback_dispatcher_tb.sv
